// ===== hdl/cfa_pkg.sv =====
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and constants of the clock frame allocator: table sizes,
// function and status codes, sweep kinds, controller states and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cfa_pkg;

	// table geometry
	localparam int FRAMES    = 64;
	localparam int IDX_W     = $clog2(FRAMES);
	localparam int CNT_W     = 7;
	localparam int ITER_W    = CNT_W + 1;
	localparam int PAGE_BITS = 20;
	localparam int FUNC_W    = 3;
	localparam int STAT_W    = 2;

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(64);

	// item function codes
	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC  = 3'd0,
		FN_TOUCH  = 3'd1,
		FN_LOCK   = 3'd2,
		FN_UNLOCK = 3'd3,
		FN_FREE   = 3'd4
	} func_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		RS_FREE  = 2'd0,
		RS_EVICT = 2'd1,
		RS_NONE  = 2'd2,
		RS_DONE  = 2'd3
	} rstat_t;

	// what the frame under the hand looks like
	typedef enum logic [1:0] {
		SK_PINNED = 2'd0,
		SK_FREE   = 2'd1,
		SK_AGED   = 2'd2,
		SK_VICTIM = 2'd3
	} sweep_kind_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE  = 3'd0,
		S_EXEC  = 3'd1,
		S_SCAN  = 3'd2,
		S_SWEEP = 3'd3,
		S_EVICT = 3'd4,
		S_RESP  = 3'd5
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic op_apply;
		logic alloc_fail;
		logic scan_start;
		logic scan_step;
		logic scan_claim;
		logic sweep_start;
		logic sweep_step;
		logic evict_claim;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic        is_alloc;
		logic        n_zero;
		logic        scan_hit;
		logic        scan_last;
		sweep_kind_t sweep_kind;
		logic        sweep_last;
		logic        out_free;
	} stat_t;

endpackage

// ===== hdl/clock_frame_allocator_unit.sv =====
// Sequence: touch, lock, unlock, free and unknown functions go from decode to
//   the result; alloc over live frames adds scan, sweep and, for a victim, eviction.
// Throughput: one item at a time; the longest alloc is set by the
//   one-frame-per-cycle scan and the sweep of up to twice the frames.
// Reset: arst_n clears flags, hand and output valid; frame count returns to 64.
// ----------------------------------------------------------------------------
// clock_frame_allocator_unit
// Second-chance frame allocator: a frame table with pinned, occupied and
// accessed bits, owner pages and a clock hand, driven by a small sequencer.
// ----------------------------------------------------------------------------
module clock_frame_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cfa_pkg::FUNC_W-1:0]    func,
	input  logic [cfa_pkg::IDX_W-1:0]     frame_index,
	input  logic [cfa_pkg::PAGE_BITS-1:0] page_id,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cfa_pkg::STAT_W-1:0]    status,
	output logic [cfa_pkg::IDX_W-1:0]     frame_index_out,
	output logic [cfa_pkg::PAGE_BITS-1:0] victim_page,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cfa_pkg::CNT_W-1:0]     frame_count
);

	cfa_pkg::cmd_t  cmd;
	cfa_pkg::stat_t stat;

	// frame count writes always land
	assign cfg_ready = 1'b1;

	cfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	cfa_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_valid       (cfg_valid),
		.frame_count     (frame_count),
		.func            (func),
		.frame_index     (frame_index),
		.page_id         (page_id),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.frame_index_out (frame_index_out),
		.victim_page     (victim_page)
	);

endmodule

// ===== hdl/cfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfa_ctrl
// Sequencer of the frame allocator: walks one item through decode, the
// first-free scan, the clock sweep, eviction and result hand-off.
// ----------------------------------------------------------------------------
module cfa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  cfa_pkg::stat_t stat,
	output cfa_pkg::cmd_t  cmd,
	output logic           in_stall
);

	cfa_pkg::state_t state_q, state_nxt;
	logic            sweep_miss;

	// hand passes over the frame without claiming it
	assign sweep_miss = (stat.sweep_kind == cfa_pkg::SK_PINNED) ||
		(stat.sweep_kind == cfa_pkg::SK_AGED);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfa_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			cfa_pkg::S_IDLE: begin
				if (in_valid) state_nxt = cfa_pkg::S_EXEC;
			end
			cfa_pkg::S_EXEC: begin
				if (!stat.is_alloc || stat.n_zero) state_nxt = cfa_pkg::S_RESP;
				else state_nxt = cfa_pkg::S_SCAN;
			end
			cfa_pkg::S_SCAN: begin
				if (stat.scan_hit) state_nxt = cfa_pkg::S_RESP;
				else if (stat.scan_last) state_nxt = cfa_pkg::S_SWEEP;
			end
			cfa_pkg::S_SWEEP: begin
				if (stat.sweep_kind == cfa_pkg::SK_FREE) state_nxt = cfa_pkg::S_RESP;
				else if (stat.sweep_kind == cfa_pkg::SK_VICTIM) state_nxt = cfa_pkg::S_EVICT;
				else if (stat.sweep_last) state_nxt = cfa_pkg::S_RESP;
			end
			cfa_pkg::S_EVICT: begin
				state_nxt = cfa_pkg::S_RESP;
			end
			cfa_pkg::S_RESP: begin
				if (stat.out_free) state_nxt = cfa_pkg::S_IDLE;
			end
			default: begin
				state_nxt = cfa_pkg::S_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			cfa_pkg::S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			cfa_pkg::S_EXEC: begin
				if (!stat.is_alloc) cmd.op_apply = 1'b1;
				else if (stat.n_zero) cmd.alloc_fail = 1'b1;
				else cmd.scan_start = 1'b1;
			end
			cfa_pkg::S_SCAN: begin
				if (stat.scan_hit) cmd.scan_claim = 1'b1;
				else if (stat.scan_last) cmd.sweep_start = 1'b1;
				else cmd.scan_step = 1'b1;
			end
			cfa_pkg::S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				cmd.alloc_fail = sweep_miss && stat.sweep_last;
			end
			cfa_pkg::S_EVICT: begin
				cmd.evict_claim = 1'b1;
			end
			cfa_pkg::S_RESP: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== hdl/cfa_dpath.sv =====
// ----------------------------------------------------------------------------
// cfa_dpath
// Frame table, clock hand, scan counters, owner page memory, pending result
// and the output register of the frame allocator.
// ----------------------------------------------------------------------------
module cfa_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfa_pkg::cmd_t                 cmd,
	output cfa_pkg::stat_t                stat,
	input  logic                          cfg_valid,
	input  logic [cfa_pkg::CNT_W-1:0]     frame_count,
	input  logic [cfa_pkg::FUNC_W-1:0]    func,
	input  logic [cfa_pkg::IDX_W-1:0]     frame_index,
	input  logic [cfa_pkg::PAGE_BITS-1:0] page_id,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cfa_pkg::STAT_W-1:0]    status,
	output logic [cfa_pkg::IDX_W-1:0]     frame_index_out,
	output logic [cfa_pkg::PAGE_BITS-1:0] victim_page
);

	// item and configuration registers
	cfa_pkg::func_t                func_q;
	logic [cfa_pkg::IDX_W-1:0]     idx_q;
	logic [cfa_pkg::PAGE_BITS-1:0] page_q;
	logic [cfa_pkg::CNT_W-1:0]     count_q;

	// frame table
	logic [cfa_pkg::FRAMES-1:0]    occ_q, pin_q, acc_q;
	logic [cfa_pkg::PAGE_BITS-1:0] own_mem [cfa_pkg::FRAMES];
	logic [cfa_pkg::PAGE_BITS-1:0] own_rd_q;

	// walk state
	logic [cfa_pkg::IDX_W-1:0]  hand_q, ptr_q;
	logic [cfa_pkg::ITER_W-1:0] iter_q;

	// pending result and output register
	cfa_pkg::rstat_t               res_stat_q;
	logic [cfa_pkg::IDX_W-1:0]     res_idx_q;
	logic [cfa_pkg::PAGE_BITS-1:0] res_vic_q;
	logic                          out_valid_q;
	logic [cfa_pkg::STAT_W-1:0]    out_stat_q;
	logic [cfa_pkg::IDX_W-1:0]     out_idx_q;
	logic [cfa_pkg::PAGE_BITS-1:0] out_vic_q;

	logic [cfa_pkg::CNT_W-1:0]  n_live;
	logic [cfa_pkg::CNT_W-1:0]  hand_inc;
	logic [cfa_pkg::IDX_W-1:0]  hand_adv;
	logic [cfa_pkg::ITER_W-1:0] iter_end;
	logic                       idx_ok;
	logic                       sweep_free;
	logic                       claim_en;
	logic [cfa_pkg::IDX_W-1:0]  claim_addr;

	// frames in use, clamped to the table size
	assign n_live = (count_q > cfa_pkg::CNT_W'(cfa_pkg::FRAMES)) ?
		cfa_pkg::CNT_W'(cfa_pkg::FRAMES) : count_q;

	// hand advance with wrap at the live count
	assign hand_inc = {1'b0, hand_q} + cfa_pkg::CNT_W'(1);
	assign hand_adv = (hand_inc >= n_live) ? '0 : hand_inc[cfa_pkg::IDX_W-1:0];

	// sweep bound is twice the live count
	assign iter_end = {n_live, 1'b0} - cfa_pkg::ITER_W'(1);
	assign idx_ok   = ({1'b0, idx_q} < n_live);

	// classify the frame under the hand
	assign stat.sweep_kind = pin_q[hand_q] ? cfa_pkg::SK_PINNED :
		!occ_q[hand_q] ? cfa_pkg::SK_FREE :
		acc_q[hand_q] ? cfa_pkg::SK_AGED : cfa_pkg::SK_VICTIM;

	assign sweep_free = cmd.sweep_step && (stat.sweep_kind == cfa_pkg::SK_FREE);

	// status to the controller
	assign stat.is_alloc   = (func_q == cfa_pkg::FN_ALLOC);
	assign stat.n_zero     = (n_live == '0);
	assign stat.scan_hit   = !occ_q[ptr_q] && !pin_q[ptr_q];
	assign stat.scan_last  = (({1'b0, ptr_q} + cfa_pkg::CNT_W'(1)) == n_live);
	assign stat.sweep_last = (iter_q == iter_end);
	assign stat.out_free   = !out_valid_q || !out_stall;

	// claim port
	assign claim_en   = cmd.scan_claim || sweep_free || cmd.evict_claim;
	assign claim_addr = sweep_free ? hand_q : ptr_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= cfa_pkg::CNT_RESET;
		end else if (cfg_valid) begin
			count_q <= frame_count;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= cfa_pkg::func_t'(func);
			idx_q  <= frame_index;
			page_q <= page_id;
		end
	end

	// frame flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			pin_q <= '0;
			acc_q <= '0;
		end else if (claim_en) begin
			occ_q[claim_addr] <= 1'b1;
			pin_q[claim_addr] <= 1'b1;
			acc_q[claim_addr] <= 1'b0;
		end else if (cmd.sweep_step && (stat.sweep_kind == cfa_pkg::SK_AGED)) begin
			acc_q[hand_q] <= 1'b0;
		end else if (cmd.op_apply && idx_ok) begin
			case (func_q)
				cfa_pkg::FN_TOUCH: begin
					acc_q[idx_q] <= 1'b1;
				end
				cfa_pkg::FN_LOCK: begin
					pin_q[idx_q] <= 1'b1;
				end
				cfa_pkg::FN_UNLOCK: begin
					pin_q[idx_q] <= 1'b0;
				end
				cfa_pkg::FN_FREE: begin
					occ_q[idx_q] <= 1'b0;
					pin_q[idx_q] <= 1'b0;
					acc_q[idx_q] <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// owner page memory, read follows the hand
	always_ff @(posedge clk) begin
		if (claim_en) own_mem[claim_addr] <= page_q;
		own_rd_q <= own_mem[hand_q];
	end

	// scan pointer, clock hand and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hand_q <= '0;
			ptr_q  <= '0;
			iter_q <= '0;
		end else begin
			if (cmd.scan_start) ptr_q <= '0;
			else if (cmd.scan_step) ptr_q <= ptr_q + cfa_pkg::IDX_W'(1);
			else if (cmd.sweep_step) ptr_q <= hand_q;

			if (cmd.sweep_start) begin
				if ({1'b0, hand_q} >= n_live) hand_q <= '0;
				iter_q <= '0;
			end else if (cmd.sweep_step) begin
				hand_q <= hand_adv;
				iter_q <= iter_q + cfa_pkg::ITER_W'(1);
			end
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (cmd.op_apply) begin
			res_stat_q <= cfa_pkg::RS_DONE;
			res_idx_q  <= idx_q;
			res_vic_q  <= '0;
		end else if (cmd.alloc_fail) begin
			res_stat_q <= cfa_pkg::RS_NONE;
			res_idx_q  <= '0;
			res_vic_q  <= '0;
		end else if (cmd.scan_claim || sweep_free) begin
			res_stat_q <= cfa_pkg::RS_FREE;
			res_idx_q  <= claim_addr;
			res_vic_q  <= '0;
		end else if (cmd.evict_claim) begin
			res_stat_q <= cfa_pkg::RS_EVICT;
			res_idx_q  <= ptr_q;
			res_vic_q  <= own_rd_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_stat_q <= res_stat_q;
			out_idx_q  <= res_idx_q;
			out_vic_q  <= res_vic_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_stat_q;
	assign frame_index_out = out_idx_q;
	assign victim_page     = out_vic_q;

`ifndef SYNTH
	// the hand never claims a pinned frame
	a_no_pinned_claim: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_step && (stat.sweep_kind == cfa_pkg::SK_FREE) |-> !pin_q[hand_q])
		else $error("sweep claimed a pinned frame");

	// a claimed frame ends up occupied and pinned
	a_claim_sets: assert property (@(posedge clk) disable iff (!arst_n)
		claim_en |=> occ_q[$past(claim_addr)] && pin_q[$past(claim_addr)])
		else $error("claimed frame not occupied and pinned");

	// during a sweep the hand stays inside the live frames
	a_hand_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_step |-> ({1'b0, hand_q} < n_live))
		else $error("clock hand outside live frames");

	// a new beat is never loaded over one still held by a stall
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output beat overwritten");
`endif

endmodule

// ===== tb/cfa_response_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_response_checker
// Watches the item, result and frame-count channels of the frame allocator,
// keeps its own frame table and clock hand, predicts the response to every
// accepted item and compares each accepted result beat in order.
// ----------------------------------------------------------------------------
module cfa_response_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [cfa_pkg::FUNC_W-1:0]    func,
	input  logic [cfa_pkg::IDX_W-1:0]     frame_index,
	input  logic [cfa_pkg::PAGE_BITS-1:0] page_id,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [cfa_pkg::STAT_W-1:0]    status,
	input  logic [cfa_pkg::IDX_W-1:0]     frame_index_out,
	input  logic [cfa_pkg::PAGE_BITS-1:0] victim_page,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [cfa_pkg::CNT_W-1:0]     frame_count,
	output int                            errors,
	output int                            pending
);

	typedef struct packed {
		cfa_pkg::rstat_t               status;
		logic [cfa_pkg::IDX_W-1:0]     frame;
		logic [cfa_pkg::PAGE_BITS-1:0] victim;
	} frame_resp_t;

	// shadow frame table
	bit [cfa_pkg::FRAMES-1:0]      occ_bits;
	bit [cfa_pkg::FRAMES-1:0]      pin_bits;
	bit [cfa_pkg::FRAMES-1:0]      acc_bits;
	logic [cfa_pkg::PAGE_BITS-1:0] owner [cfa_pkg::FRAMES];
	int                            hand;
	int                            live_cnt;

	frame_resp_t resp_q [$];

	function automatic void claim_frame(input int f,
			input logic [cfa_pkg::PAGE_BITS-1:0] pg);
		occ_bits[f] = 1'b1;
		pin_bits[f] = 1'b1;
		acc_bits[f] = 1'b0;
		owner[f]    = pg;
	endfunction

	// response of one item, updating the shadow table as the block would
	function automatic frame_resp_t predict_frame_op(input logic [cfa_pkg::FUNC_W-1:0] fn,
			input logic [cfa_pkg::IDX_W-1:0] idx,
			input logic [cfa_pkg::PAGE_BITS-1:0] pg);
		frame_resp_t r;
		int          n;
		int          i;
		int          f;
		bit          found;
		n        = (live_cnt > cfa_pkg::FRAMES) ? cfa_pkg::FRAMES : live_cnt;
		r.status = cfa_pkg::RS_DONE;
		r.frame  = idx;
		r.victim = '0;
		found    = 1'b0;
		if (fn == cfa_pkg::FN_ALLOC) begin
			r.status = cfa_pkg::RS_NONE;
			r.frame  = '0;
			// first pass: lowest free, unpinned frame
			for (i = 0; i < n && !found; i++) begin
				if (!pin_bits[i] && !occ_bits[i]) begin
					claim_frame(i, pg);
					r.status = cfa_pkg::RS_FREE;
					r.frame  = cfa_pkg::IDX_W'(i);
					found    = 1'b1;
				end
			end
			// second pass: clock sweep, hand restarts if stale
			if (!found && n > 0) begin
				if (hand >= n)
					hand = 0;
				for (i = 0; i < 2 * n && !found; i++) begin
					f    = hand;
					hand = (hand + 1 >= n) ? 0 : hand + 1;
					if (pin_bits[f]) begin
						// skipped
					end else if (!occ_bits[f]) begin
						claim_frame(f, pg);
						r.status = cfa_pkg::RS_FREE;
						r.frame  = cfa_pkg::IDX_W'(f);
						found    = 1'b1;
					end else if (acc_bits[f]) begin
						acc_bits[f] = 1'b0;
					end else begin
						r.victim = owner[f];
						claim_frame(f, pg);
						r.status = cfa_pkg::RS_EVICT;
						r.frame  = cfa_pkg::IDX_W'(f);
						found    = 1'b1;
					end
				end
			end
		end else if (fn <= cfa_pkg::FN_FREE && int'(idx) < n) begin
			case (fn)
				cfa_pkg::FN_TOUCH:  acc_bits[idx] = 1'b1;
				cfa_pkg::FN_LOCK:   pin_bits[idx] = 1'b1;
				cfa_pkg::FN_UNLOCK: pin_bits[idx] = 1'b0;
				default: begin
					occ_bits[idx] = 1'b0;
					pin_bits[idx] = 1'b0;
					acc_bits[idx] = 1'b0;
				end
			endcase
		end
		return r;
	endfunction

	// beat tracking: results first, since a result never belongs to an item of the same edge
	always @(posedge clk or negedge arst_n) begin
		frame_resp_t exp_r;
		if (!arst_n) begin
			occ_bits = '0;
			pin_bits = '0;
			acc_bits = '0;
			hand     = 0;
			live_cnt = int'(cfa_pkg::CNT_RESET);
			resp_q.delete();
			errors   = 0;
			pending  = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (resp_q.size() == 0) begin
					$error("result beat with no item outstanding: status %0d frame %0d",
						status, frame_index_out);
					errors++;
				end else begin
					exp_r = resp_q.pop_front();
					if (status !== exp_r.status) begin
						$error("status: expected %0d, actual %0d", exp_r.status, status);
						errors++;
					end
					if (frame_index_out !== exp_r.frame) begin
						$error("frame_index_out: expected %0d, actual %0d",
							exp_r.frame, frame_index_out);
						errors++;
					end
					if (victim_page !== exp_r.victim) begin
						$error("victim_page: expected %0h, actual %0h",
							exp_r.victim, victim_page);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				live_cnt = int'(frame_count);
			if (in_valid && !in_stall)
				resp_q.push_back(predict_frame_op(func, frame_index, page_id));
			pending = resp_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the clock frame allocator: a directed opening over every
// function and corner of the sweep, then random phases at several frame
// counts with random gaps, receiver stalls, one long hold-off and one drain.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 95;
	localparam int TAIL_CYCLES  = 16;
	localparam int TIMEOUT_NS   = 20_000_000;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [cfa_pkg::FUNC_W-1:0]    func;
	logic [cfa_pkg::IDX_W-1:0]     frame_index;
	logic [cfa_pkg::PAGE_BITS-1:0] page_id;
	logic                          out_valid;
	logic                          out_stall;
	logic [cfa_pkg::STAT_W-1:0]    status;
	logic [cfa_pkg::IDX_W-1:0]     frame_index_out;
	logic [cfa_pkg::PAGE_BITS-1:0] victim_page;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [cfa_pkg::CNT_W-1:0]     frame_count;

	int chk_errors;
	int chk_pending;
	int cur_count;
	bit steady;
	bit hold_go;
	bit hold_done;
	int hold_left;

	clock_frame_allocator_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.frame_index     (frame_index),
		.page_id         (page_id),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.frame_index_out (frame_index_out),
		.victim_page     (victim_page),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.frame_count     (frame_count)
	);

	cfa_response_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.frame_index     (frame_index),
		.page_id         (page_id),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.frame_index_out (frame_index_out),
		.victim_page     (victim_page),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.frame_count     (frame_count),
		.errors          (chk_errors),
		.pending         (chk_pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		out_stall = 1'b0;
		hold_done = 1'b0;
		hold_left = 0;
		forever @(negedge clk) begin
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(0, 99) < 10);
			end
		end
	end

	// one item beat, with an occasional idle gap ahead of it
	task automatic send_beat(input logic [cfa_pkg::FUNC_W-1:0] fn,
			input logic [cfa_pkg::IDX_W-1:0] idx,
			input logic [cfa_pkg::PAGE_BITS-1:0] pg);
		int gap;
		if (!steady && $urandom_range(0, 99) < 10) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		func        <= fn;
		frame_index <= idx;
		page_id     <= pg;
		do @(posedge clk); while (in_stall);
	endtask

	// stop offering items until every response is back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (chk_pending != 0) @(negedge clk);
	endtask

	task automatic set_frame_count(input int v);
		wait_drained();
		cfg_valid   <= 1'b1;
		frame_count <= cfa_pkg::CNT_W'(v);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_count = v;
	endtask

	// target mostly inside the live frames, sometimes anywhere
	function automatic logic [cfa_pkg::IDX_W-1:0] pick_index(input int cnt);
		int n;
		n = (cnt > cfa_pkg::FRAMES) ? cfa_pkg::FRAMES : cnt;
		if (n == 0 || $urandom_range(0, 7) == 0)
			return cfa_pkg::IDX_W'($urandom_range(0, cfa_pkg::FRAMES - 1));
		return cfa_pkg::IDX_W'($urandom_range(0, n - 1));
	endfunction

	task automatic random_item();
		int                            r;
		logic [cfa_pkg::FUNC_W-1:0]    fn;
		logic [cfa_pkg::PAGE_BITS-1:0] pg;
		r = $urandom_range(0, 99);
		if (r < 35)
			fn = cfa_pkg::FN_ALLOC;
		else if (r < 50)
			fn = cfa_pkg::FN_TOUCH;
		else if (r < 60)
			fn = cfa_pkg::FN_LOCK;
		else if (r < 85)
			fn = cfa_pkg::FN_UNLOCK;
		else if (r < 95)
			fn = cfa_pkg::FN_FREE;
		else
			fn = cfa_pkg::FUNC_W'($urandom_range(int'(cfa_pkg::FN_FREE) + 1,
				(1 << cfa_pkg::FUNC_W) - 1));
		case ($urandom_range(0, 15))
			0:       pg = '0;
			1:       pg = '1;
			default: pg = cfa_pkg::PAGE_BITS'($urandom);
		endcase
		send_beat(fn, pick_index(cur_count), pg);
	endtask

	// stimulus
	initial begin
		int p;
		int k;
		int cnt;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = '0;
		frame_index = '0;
		page_id     = '0;
		cfg_valid   = 1'b0;
		frame_count = cfa_pkg::CNT_RESET;
		cur_count   = int'(cfa_pkg::CNT_RESET);
		steady      = 1'b0;
		hold_go     = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every function at the reset count, page extremes, unknown codes
		send_beat(cfa_pkg::FN_ALLOC, '0, '0);
		send_beat(cfa_pkg::FN_ALLOC, '1, '1);
		send_beat(cfa_pkg::FN_TOUCH, cfa_pkg::IDX_W'(0), cfa_pkg::PAGE_BITS'($urandom));
		send_beat(cfa_pkg::FN_LOCK, '1, cfa_pkg::PAGE_BITS'($urandom));
		send_beat(cfa_pkg::FN_UNLOCK, cfa_pkg::IDX_W'(0), cfa_pkg::PAGE_BITS'($urandom));
		send_beat(cfa_pkg::FN_UNLOCK, '1, cfa_pkg::PAGE_BITS'($urandom));
		send_beat(cfa_pkg::FN_FREE, cfa_pkg::IDX_W'(1), cfa_pkg::PAGE_BITS'($urandom));
		send_beat(cfa_pkg::FUNC_W'(int'(cfa_pkg::FN_FREE) + 1), '1,
			cfa_pkg::PAGE_BITS'($urandom));
		send_beat(cfa_pkg::FUNC_W'(int'(cfa_pkg::FN_FREE) + 2), cfa_pkg::IDX_W'(21),
			cfa_pkg::PAGE_BITS'($urandom));
		send_beat('1, cfa_pkg::IDX_W'(0), '1);

		// two frames: free claim, second-chance eviction, all-pinned failure
		set_frame_count(2);
		send_beat(cfa_pkg::FN_ALLOC, '0, cfa_pkg::PAGE_BITS'('h12345));
		send_beat(cfa_pkg::FN_ALLOC, '0, cfa_pkg::PAGE_BITS'('h54321));
		send_beat(cfa_pkg::FN_ALLOC, '0, cfa_pkg::PAGE_BITS'('h0f0f0));
		send_beat(cfa_pkg::FN_TOUCH, cfa_pkg::IDX_W'(2), '0);
		send_beat(cfa_pkg::FN_FREE, '1, '0);
		send_beat(cfa_pkg::FN_UNLOCK, cfa_pkg::IDX_W'(0), '0);
		send_beat(cfa_pkg::FN_UNLOCK, cfa_pkg::IDX_W'(1), '0);
		send_beat(cfa_pkg::FN_TOUCH, cfa_pkg::IDX_W'(1), '0);
		send_beat(cfa_pkg::FN_ALLOC, '0, cfa_pkg::PAGE_BITS'('habcde));

		// one frame: hand left past the count restarts at frame zero
		set_frame_count(1);
		send_beat(cfa_pkg::FN_ALLOC, '0, cfa_pkg::PAGE_BITS'('h11111));
		send_beat(cfa_pkg::FN_UNLOCK, cfa_pkg::IDX_W'(0), '0);
		send_beat(cfa_pkg::FN_ALLOC, '0, cfa_pkg::PAGE_BITS'('h22222));

		// no frames at all
		set_frame_count(0);
		send_beat(cfa_pkg::FN_ALLOC, '0, cfa_pkg::PAGE_BITS'('h33333));
		send_beat(cfa_pkg::FN_TOUCH, cfa_pkg::IDX_W'(0), '0);

		// count above the table size
		set_frame_count((1 << cfa_pkg::CNT_W) - 1);
		send_beat(cfa_pkg::FN_ALLOC, '0, cfa_pkg::PAGE_BITS'('h44444));

		// random phases over a range of frame counts
		for (p = 0; p < 10; p++) begin
			case (p)
				0:       cnt = 8;
				1:       cnt = cfa_pkg::FRAMES;
				2:       cnt = 3;
				3:       cnt = (1 << cfa_pkg::CNT_W) - 1;
				4:       cnt = 16;
				5:       cnt = 1;
				6:       cnt = $urandom_range(0, (1 << cfa_pkg::CNT_W) - 1);
				7:       cnt = 0;
				8:       cnt = 100;
				default: cnt = cfa_pkg::FRAMES;
			endcase
			set_frame_count(cnt);
			steady = (p == 1);
			if (p == 4)
				hold_go = 1'b1;
			for (k = 0; k < ((cnt == 0) ? 20 : PHASE_ITEMS); k++) begin
				if (p == 5 && k == PHASE_ITEMS / 2)
					wait_drained();
				random_item();
			end
		end
		steady = 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (chk_errors == 0 && chk_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
